// ----- hdl/tpi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tpi_pkg;

  // Field and intermediate widths
  localparam int NRM_W = 18;   // normal component, Q2.16
  localparam int OFF_W = 32;   // offset and point, Q16.16
  localparam int PRD_W = 36;   // normal times normal
  localparam int CRS_W = 37;   // cross product component
  localparam int DP_W  = 55;   // normal times cross component
  localparam int NP_W  = 69;   // offset times cross component
  localparam int DEN_W = 57;   // triple product
  localparam int NUM_W = 71;   // numerator sum
  localparam int FRAC  = 16;   // extra fraction bits of the quotient
  localparam int QW    = 32;   // quotient bits

  // One classified item from the front to the back
  typedef struct packed {
    logic                        hit;
    logic                        den_neg;
    logic [DEN_W-1:0]            dm;
    logic [2:0]                  nneg;
    logic [2:0][NUM_W-1:0]       mag;
  } tpi_job_t;

  // Next and previous axis index, for cross products
  function automatic int nxt(input int k);
    nxt = (k == 2) ? 0 : k + 1;
  endfunction

  function automatic int prv(input int k);
    prv = (k == 0) ? 2 : k - 1;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/tpi_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Plane triple channel
interface tpi_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [17:0]      a_nx;
  logic signed [17:0]      a_ny;
  logic signed [17:0]      a_nz;
  logic signed [31:0]      a_off;
  logic signed [17:0]      b_nx;
  logic signed [17:0]      b_ny;
  logic signed [17:0]      b_nz;
  logic signed [31:0]      b_off;
  logic signed [17:0]      c_nx;
  logic signed [17:0]      c_ny;
  logic signed [17:0]      c_nz;
  logic signed [31:0]      c_off;

  modport source (output valid, a_nx, a_ny, a_nz, a_off, b_nx, b_ny, b_nz, b_off,
                  c_nx, c_ny, c_nz, c_off, input ready);
  modport sink (input valid, a_nx, a_ny, a_nz, a_off, b_nx, b_ny, b_nz, b_off,
                c_nx, c_ny, c_nz, c_off, output ready);
endinterface

// Intersection point channel
interface tpi_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] pt_x;
  logic signed [31:0] pt_y;
  logic signed [31:0] pt_z;
  logic               clipped;

  modport source (output valid, hit, pt_x, pt_y, pt_z, clipped, input ready);
  modport sink (input valid, hit, pt_x, pt_y, pt_z, clipped, output ready);
endinterface
`default_nettype wire

// ----- hdl/three_plane_intersection.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Three-plane intersection point.
// in_ch carries three planes (normals Q2.16, offsets Q16.16); out_ch carries
// hit, the point (Q16.16, saturated) and the clipped flag, one result per item.
// Both channels use valid/ready; an item moves when both are high.
// Front: four stages of multiply and add form the cross products, the triple
// product and the three numerators, then classify the item into a small queue.
// Back: one register stage loads the divider, 32 restoring-division stages
// (one quotient bit each, all three coordinates in parallel) follow, and the
// output register applies sign and saturation.
// Stages: 4 front stages, then the queue, then 34 back stages.
// Throughput: one item per cycle while results are taken; the divider
// stage count sets the latency. When the receiver stalls, the back holds; the
// front keeps accepting until the queue (QUEUE_DEPTH items) is full and its
// own last stage holds an item, then drops ready.
// Reset clears all valid bits and queue pointers; out_ch.valid and in_ch.ready
// are low while rst is high.
module three_plane_intersection
  import tpi_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  tpi_in_if.sink    in_ch,
  tpi_out_if.source out_ch
);

  tpi_job_t push_job;
  tpi_job_t pop_job;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  tpi_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  tpi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_job),
    .full  (q_full),
    .pop   (pop),
    .dout  (pop_job),
    .empty (q_empty)
  );

  tpi_back u_back (
    .clk    (clk),
    .rst    (rst),
    .job    (pop_job),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ----- hdl/tpi_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpi_front
  import tpi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  tpi_in_if.sink     in_ch,
  input  wire logic  q_full,
  output logic       push,
  output tpi_job_t   job
);

  logic [3:0] vld;
  logic       adv;

  logic signed [NRM_W-1:0] na [3];
  logic signed [NRM_W-1:0] nb [3];
  logic signed [NRM_W-1:0] nc [3];
  logic signed [OFF_W-1:0] dd [3];

  logic signed [PRD_W-1:0] s1_pu [3][3];
  logic signed [PRD_W-1:0] s1_pv [3][3];
  logic signed [NRM_W-1:0] s1_na [3];
  logic signed [OFF_W-1:0] s1_d  [3];

  logic signed [CRS_W-1:0] s2_cr [3][3];
  logic signed [NRM_W-1:0] s2_na [3];
  logic signed [OFF_W-1:0] s2_d  [3];

  logic signed [DP_W-1:0]  s3_dp [3];
  logic signed [NP_W-1:0]  s3_np [3][3];

  logic signed [DEN_W-1:0] s4_den;
  logic signed [NUM_W-1:0] s4_num [3];

  // Stall the whole front only when its last stage cannot enter the queue
  assign adv         = !(vld[3] && q_full);
  assign in_ch.ready = adv && !rst;
  assign push        = vld[3] && !q_full;

  assign na[0] = in_ch.a_nx;
  assign na[1] = in_ch.a_ny;
  assign na[2] = in_ch.a_nz;
  assign nb[0] = in_ch.b_nx;
  assign nb[1] = in_ch.b_ny;
  assign nb[2] = in_ch.b_nz;
  assign nc[0] = in_ch.c_nx;
  assign nc[1] = in_ch.c_ny;
  assign nc[2] = in_ch.c_nz;
  assign dd[0] = in_ch.a_off;
  assign dd[1] = in_ch.b_off;
  assign dd[2] = in_ch.c_off;

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_ch.valid};
    end
  end

  // Products of normals, then cross products, then scaled terms, then sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s1_pu[0][k] <= PRD_W'(nb[nxt(k)]) * PRD_W'(nc[prv(k)]);
        s1_pv[0][k] <= PRD_W'(nb[prv(k)]) * PRD_W'(nc[nxt(k)]);
        s1_pu[1][k] <= PRD_W'(nc[nxt(k)]) * PRD_W'(na[prv(k)]);
        s1_pv[1][k] <= PRD_W'(nc[prv(k)]) * PRD_W'(na[nxt(k)]);
        s1_pu[2][k] <= PRD_W'(na[nxt(k)]) * PRD_W'(nb[prv(k)]);
        s1_pv[2][k] <= PRD_W'(na[prv(k)]) * PRD_W'(nb[nxt(k)]);
        s1_na[k]    <= na[k];
        s1_d[k]     <= dd[k];
      end
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 3; k++) begin
          s2_cr[c][k] <= CRS_W'(s1_pu[c][k]) - CRS_W'(s1_pv[c][k]);
        end
        s2_na[c] <= s1_na[c];
        s2_d[c]  <= s1_d[c];
      end
      for (int k = 0; k < 3; k++) begin
        s3_dp[k] <= DP_W'(s2_na[k]) * DP_W'(s2_cr[0][k]);
        for (int c = 0; c < 3; c++) begin
          s3_np[c][k] <= NP_W'(s2_d[c]) * NP_W'(s2_cr[c][k]);
        end
      end
      s4_den <= DEN_W'(s3_dp[0]) + DEN_W'(s3_dp[1]) + DEN_W'(s3_dp[2]);
      for (int k = 0; k < 3; k++) begin
        s4_num[k] <= NUM_W'(s3_np[0][k]) + NUM_W'(s3_np[1][k]) + NUM_W'(s3_np[2][k]);
      end
    end
  end

  // Classify: zero test, signs and magnitudes
  always_comb begin
    job.hit     = (s4_den != '0);
    job.den_neg = s4_den[DEN_W-1];
    job.dm      = job.den_neg ? DEN_W'(-s4_den) : DEN_W'(s4_den);
    for (int k = 0; k < 3; k++) begin
      job.nneg[k] = s4_num[k][NUM_W-1];
      job.mag[k]  = job.nneg[k] ? NUM_W'(-s4_num[k]) : NUM_W'(s4_num[k]);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tpi_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpi_queue
  import tpi_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire tpi_job_t din,
  output logic          full,
  input  wire logic     pop,
  output tpi_job_t      dout,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tpi_job_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Move pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tpi_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpi_back
  import tpi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire tpi_job_t job,
  input  wire logic     empty,
  output logic          pop,
  tpi_out_if.source     out_ch
);

  // One stage of the divider pipeline, all three coordinates side by side
  typedef struct packed {
    logic                  hit;
    logic                  den_neg;
    logic [DEN_W-1:0]      dm;
    logic [2:0]            nneg;
    logic [2:0]            big;
    logic [2:0][DEN_W-1:0] rem;
    logic [2:0][QW-1:0]    q;
    logic [2:0][QW-1:0]    sh;
  } tpi_div_t;

  localparam logic [QW:0] LIM_POS = {2'b00, {(QW-1){1'b1}}};
  localparam logic [QW:0] LIM_NEG = {2'b01, {(QW-1){1'b0}}};

  tpi_div_t         st [QW+1];
  logic [QW:0]      bvld;
  logic             adv;
  logic [2:0][QW-1:0] res;
  logic [2:0]       clip;

  // Load a job: overflow test and first partial remainder
  function automatic tpi_div_t div_init(input tpi_job_t j);
    tpi_div_t s;
    s.hit     = j.hit;
    s.den_neg = j.den_neg;
    s.dm      = j.dm;
    s.nneg    = j.nneg;
    for (int k = 0; k < 3; k++) begin
      s.big[k] = DEN_W'(j.mag[k] >> FRAC) >= j.dm;
      s.rem[k] = DEN_W'(j.mag[k] >> FRAC);
      s.q[k]   = '0;
      s.sh[k]  = {j.mag[k][FRAC-1:0], {(QW-FRAC){1'b0}}};
    end
    return s;
  endfunction

  // One restoring division step per coordinate
  function automatic tpi_div_t div_step(input tpi_div_t a);
    tpi_div_t     s;
    logic [DEN_W:0] trial;
    s = a;
    for (int k = 0; k < 3; k++) begin
      trial = {a.rem[k], a.sh[k][QW-1]};
      if (trial >= {1'b0, a.dm}) begin
        s.rem[k] = DEN_W'(trial - {1'b0, a.dm});
        s.q[k]   = {a.q[k][QW-2:0], 1'b1};
      end else begin
        s.rem[k] = trial[DEN_W-1:0];
        s.q[k]   = {a.q[k][QW-2:0], 1'b0};
      end
      s.sh[k] = {a.sh[k][QW-2:0], 1'b0};
    end
    return s;
  endfunction

  assign adv = !out_ch.valid || out_ch.ready;
  assign pop = adv && !empty;

  // Advance valid bits and the output flag
  always_ff @(posedge clk) begin
    if (rst) begin
      bvld         <= '0;
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      bvld         <= {bvld[QW-1:0], pop};
      out_ch.valid <= bvld[QW];
    end
  end

  // Divider stages
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= div_init(job);
      for (int j = 0; j < QW; j++) begin
        st[j+1] <= div_step(st[j]);
      end
    end
  end

  // Apply sign, clamp to range
  always_comb begin
    logic        neg;
    logic [QW:0] lim;
    logic [QW:0] mag;
    for (int k = 0; k < 3; k++) begin
      neg     = ((st[QW].q[k] != '0) || st[QW].big[k]) && (st[QW].nneg[k] == st[QW].den_neg);
      lim     = neg ? LIM_NEG : LIM_POS;
      clip[k] = st[QW].big[k] || ({1'b0, st[QW].q[k]} > lim);
      mag     = clip[k] ? lim : {1'b0, st[QW].q[k]};
      res[k]  = neg ? QW'(-mag) : QW'(mag);
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.hit     <= st[QW].hit;
      out_ch.pt_x    <= st[QW].hit ? res[0] : '0;
      out_ch.pt_y    <= st[QW].hit ? res[1] : '0;
      out_ch.pt_z    <= st[QW].hit ? res[2] : '0;
      out_ch.clipped <= st[QW].hit && (clip != '0);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tpi_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        valid,
  input wire logic        ready,
  input wire logic        hit,
  input wire logic [31:0] pt_x,
  input wire logic [31:0] pt_y,
  input wire logic [31:0] pt_z,
  input wire logic        clipped
);

  localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] PMIN = 32'h8000_0000;

  // Nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid right after reset");

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("result dropped while stalled");

  // A miss carries a zero point and no clip
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !hit |-> (pt_x == '0) && (pt_y == '0) && (pt_z == '0) && !clipped)
    else $error("miss with nonzero payload");

  // A clipped result has some coordinate at a bound
  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    valid && clipped |-> hit && (pt_x == PMAX || pt_x == PMIN || pt_y == PMAX ||
                                 pt_y == PMIN || pt_z == PMAX || pt_z == PMIN))
    else $error("clipped without a saturated coordinate");

endmodule

bind three_plane_intersection tpi_checker u_chk (
  .clk     (clk),
  .rst     (rst),
  .valid   (out_ch.valid),
  .ready   (out_ch.ready),
  .hit     (out_ch.hit),
  .pt_x    (out_ch.pt_x),
  .pt_y    (out_ch.pt_y),
  .pt_z    (out_ch.pt_z),
  .clipped (out_ch.clipped)
);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import tpi_pkg::*;

  // One plane triple: rows are planes a, b, c; columns are x, y, z
  typedef struct {
    logic [NRM_W-1:0] nrm[3][3];
    logic [OFF_W-1:0] off[3];
  } plane_set_t;

  // One intersection result
  typedef struct {
    logic             hit;
    logic [OFF_W-1:0] pt[3];
    logic             clipped;
  } point_t;

  typedef enum int {MIX_FULL, MIX_UNIT, MIX_DEGEN, MIX_THIN} mix_kind_e;

  // Exact intersection predictor and queue of points still owed by the block
  class point_board;
    point_t pending[$];
    int     errors;

    function point_t predict(plane_set_t p);
      longint              n[3][3];
      longint              bc[3], ca[3], ab[3];
      longint              den;
      logic signed [127:0] da, db, dc, x, y, z, num, q, dw, lo_lim, hi_lim;
      point_t              r;
      int                  k1, k2;
      r.hit = 0;
      r.clipped = 0;
      for (int k = 0; k < 3; k++) r.pt[k] = '0;
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++) n[i][k] = $signed(p.nrm[i][k]);
      // cross products b x c, c x a, a x b
      for (int k = 0; k < 3; k++) begin
        k1 = (k + 1) % 3;
        k2 = (k + 2) % 3;
        bc[k] = n[1][k1] * n[2][k2] - n[1][k2] * n[2][k1];
        ca[k] = n[2][k1] * n[0][k2] - n[2][k2] * n[0][k1];
        ab[k] = n[0][k1] * n[1][k2] - n[0][k2] * n[1][k1];
      end
      den = n[0][0] * bc[0] + n[0][1] * bc[1] + n[0][2] * bc[2];
      if (den == 0) return r;
      r.hit = 1;
      dw = den;
      dw = -dw;
      da = $signed(p.off[0]);
      db = $signed(p.off[1]);
      dc = $signed(p.off[2]);
      hi_lim = 128'sd2147483647;
      lo_lim = -128'sd2147483648;
      // divide with truncation toward zero, then clamp to 32 bits
      for (int k = 0; k < 3; k++) begin
        x = bc[k];
        y = ca[k];
        z = ab[k];
        num = da * x + db * y + dc * z;
        q = (num <<< FRAC) / dw;
        if (q > hi_lim) begin
          q = hi_lim;
          r.clipped = 1;
        end else if (q < lo_lim) begin
          q = lo_lim;
          r.clipped = 1;
        end
        r.pt[k] = q[31:0];
      end
      return r;
    endfunction

    function void note_input(plane_set_t p);
      pending = {pending, predict(p)};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    task check_result(point_t got);
      point_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 32'(got.hit), 32'h0);
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit) report("hit", 32'(got.hit), 32'(want.hit));
      if (got.pt[0] !== want.pt[0]) report("pt_x", got.pt[0], want.pt[0]);
      if (got.pt[1] !== want.pt[1]) report("pt_y", got.pt[1], want.pt[1]);
      if (got.pt[2] !== want.pt[2]) report("pt_z", got.pt[2], want.pt[2]);
      if (got.clipped !== want.clipped)
        report("clipped", 32'(got.clipped), 32'(want.clipped));
    endtask
  endclass

  logic       clk = 0;
  logic       rst = 1;
  int         src_idle = 0;
  int         snk_idle = 0;
  int         hold_left = 0;
  point_board board = new();

  tpi_in_if  in_ch();
  tpi_out_if out_ch();

  three_plane_intersection u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    plane_set_t p;
    point_t     r;
    if (!rst && in_ch.valid && in_ch.ready) begin
      p.nrm[0] = '{in_ch.a_nx, in_ch.a_ny, in_ch.a_nz};
      p.nrm[1] = '{in_ch.b_nx, in_ch.b_ny, in_ch.b_nz};
      p.nrm[2] = '{in_ch.c_nx, in_ch.c_ny, in_ch.c_nz};
      p.off = '{in_ch.a_off, in_ch.b_off, in_ch.c_off};
      board.note_input(p);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      r.hit = out_ch.hit;
      r.pt = '{out_ch.pt_x, out_ch.pt_y, out_ch.pt_z};
      r.clipped = out_ch.clipped;
      board.check_result(r);
    end
  end

  // Drive ready: hold off for a counted stretch, else stall at random
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task drive_fields(plane_set_t p);
    {in_ch.a_nx, in_ch.a_ny, in_ch.a_nz} = {p.nrm[0][0], p.nrm[0][1], p.nrm[0][2]};
    {in_ch.b_nx, in_ch.b_ny, in_ch.b_nz} = {p.nrm[1][0], p.nrm[1][1], p.nrm[1][2]};
    {in_ch.c_nx, in_ch.c_ny, in_ch.c_nz} = {p.nrm[2][0], p.nrm[2][1], p.nrm[2][2]};
    {in_ch.a_off, in_ch.b_off, in_ch.c_off} = {p.off[0], p.off[1], p.off[2]};
  endtask

  // Offer one item from a falling edge until accepted
  task send_item(plane_set_t p);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    drive_fields(p);
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function plane_set_t make_set(int ax, int ay, int az, int ad,
                                int bx, int by, int bz, int bd,
                                int cx, int cy, int cz, int cd);
    plane_set_t p;
    p.nrm[0] = '{ax[17:0], ay[17:0], az[17:0]};
    p.nrm[1] = '{bx[17:0], by[17:0], bz[17:0]};
    p.nrm[2] = '{cx[17:0], cy[17:0], cz[17:0]};
    p.off = '{ad, bd, cd};
    return p;
  endfunction

  function plane_set_t make_random(mix_kind_e kind);
    plane_set_t p;
    int         src;
    int         flip;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        case (kind)
          MIX_UNIT: begin
            p.nrm[i][k] = 18'($signed($urandom_range(131072)) - 65536);
          end
          MIX_THIN: begin
            p.nrm[i][k] = 18'($signed($urandom_range(6)) - 3);
          end
          default: begin
            p.nrm[i][k] = 18'($urandom);
          end
        endcase
      end
      p.off[i] = (kind == MIX_UNIT) ? 32'($signed($urandom_range(1 << 24)) - (1 << 23))
                                    : $urandom;
    end
    // copy or negate one plane normal onto another so the triple product vanishes
    if (kind == MIX_DEGEN) begin
      src = $urandom_range(2);
      flip = $urandom_range(1);
      for (int k = 0; k < 3; k++)
        p.nrm[(src + 1) % 3][k] = (flip != 0) ? -p.nrm[src][k] : p.nrm[src][k];
    end
    return p;
  endfunction

  task run_random(int count);
    int        pick;
    mix_kind_e kind;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      kind = (pick < 45) ? MIX_FULL : (pick < 75) ? MIX_UNIT :
             (pick < 88) ? MIX_DEGEN : MIX_THIN;
      send_item(make_random(kind));
    end
  endtask

  localparam int ONE  = 65536;
  localparam int NMAX = 131071;
  localparam int NMIN = -131072;
  localparam int DMAX = 32'h7fffffff;
  localparam int DMIN = 32'h80000000;

  initial begin
    in_ch.valid = 1'b0;
    out_ch.ready = 1'b0;
    drive_fields(make_set(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: zero triple product, unit axes, extremes, clipping, sign of den
    send_item(make_set(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_set(ONE, 0, 0, ONE, 0, ONE, 0, -ONE, 0, 0, ONE, 3 * ONE));
    send_item(make_set(0, ONE, 0, ONE, ONE, 0, 0, 2 * ONE, 0, 0, ONE, -ONE));
    send_item(make_set(ONE, 0, 0, DMAX, 0, ONE, 0, DMIN, 0, 0, ONE, DMAX));
    send_item(make_set(ONE, 0, 0, DMIN, 0, ONE, 0, DMAX, 0, 0, ONE, DMIN));
    send_item(make_set(ONE, 0, 0, 5, ONE, 0, 0, 7, 0, 0, ONE, 9));
    send_item(make_set(ONE, ONE, 0, 1, -ONE, -ONE, 0, 2, 0, 0, ONE, 3));
    send_item(make_set(NMAX, 0, 0, DMAX, 0, NMAX, 0, DMAX, 0, 0, NMAX, DMAX));
    send_item(make_set(NMIN, 0, 0, DMIN, 0, NMIN, 0, DMIN, 0, 0, NMIN, DMIN));
    send_item(make_set(NMIN, NMAX, NMIN, DMAX, NMAX, NMIN, NMIN, DMIN,
                       NMIN, NMIN, NMAX, DMAX));
    send_item(make_set(NMAX, NMAX, NMAX, DMIN, NMAX, NMAX, NMAX, DMAX,
                       NMAX, NMAX, NMAX, DMIN));
    send_item(make_set(1, 0, 0, DMAX, 0, 1, 0, DMIN, 0, 0, 1, DMAX));
    send_item(make_set(1, 0, 0, DMIN, 0, 1, 0, 1, 0, 0, -1, -1));
    send_item(make_set(1, 0, 0, 1, 0, 1, 0, -1, 0, 0, 1, 65536));
    send_item(make_set(-1, 0, 0, 65536, 0, 1, 0, 0, 0, 0, 1, 0));
    send_item(make_set(NMIN, 1, 0, 123456, 2, NMIN, 3, -98765,
                       0, 5, NMAX, 777777));
    send_item(make_set(ONE, 0, 0, -1, 0, ONE, 0, 1, 0, 0, ONE, -2));
    send_item(make_set(-ONE, 0, 0, ONE, 0, -ONE, 0, ONE, 0, 0, -ONE, ONE));
    send_item(make_set(3, 5, 7, DMAX, 11, 13, 17, DMIN, 19, 23, 29, DMAX));
    send_item(make_set(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));

    // random phases: few source idles, many stalls; reverse; then ready hold-off only
    src_idle = 9;
    snk_idle = 81;
    run_random(580);
    src_idle = 81;
    snk_idle = 9;
    run_random(580);
    src_idle = 0;
    snk_idle = 0;
    hold_left = 300;
    run_random(580);

    wait (board.pending.size() == 0);
    repeat (100) @(posedge clk);
    if (board.errors == 0) begin
      $display("three_plane_intersection regression: pass");
    end else begin
      $display("three_plane_intersection regression: fail");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #10ms;
    $display("three_plane_intersection regression: fail");
    $finish;
  end

endmodule
